>>> hw/rtl/assert_macros.svh
// Assertion macros for the RTL of the replacement queue.
// No dependencies; included by each module that carries assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk, off while rst is high.
`define ASSERT_AT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition never holds on a rising edge of clk.
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   `ASSERT_AT(lbl, clk, rst, !(cond), msg)

`endif

>>> hw/rtl/bfde_pkg.sv
// Shared types and constants of the bounded replacement queue.
// No dependencies; imported by the controller, datapath and top level.
package bfde_pkg;

   // Fixed port widths
   localparam int ID_W       = 16;
   localparam int COUNT_W    = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;

   // Most results reported for one item
   localparam int MAX_OUT   = 64;
   localparam int OUT_CNT_W = 7;

   // Operation codes
   localparam logic OP_ENQ    = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_ENABLE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_QUEUE_LIMIT   = 2'd1;

   // Register reset values
   localparam logic                  FILTER_RESET = 1'b1;
   localparam logic [CSR_DATA_W-1:0] QLIMIT_RESET = 7'd64;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;       // capture a new item, restart walk
      logic scan;       // walk the queue looking for the identifier
      logic shift;      // walk the queue closing a gap
      logic ev_read;    // read the oldest entry
      logic evict;      // drop the oldest entry and report it
      logic append;     // store the identifier at the tail
      logic emit_none;  // report no destruction
      logic emit_kill;  // report the identifier itself destroyed
   } ctrl_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic act;        // offered item needs queue work
      logic enq_req;    // offered item is an enqueue
      logic hit;        // scanned entry matches
      logic walk_done;  // walk reached the tail with nothing in flight
      logic lim_zero;   // effective limit is zero
      logic ev_need;    // count at or above the limit
      logic ev_more;    // count above the limit
      logic n_zero;     // nothing reported yet for this item
      logic n_full;     // report budget used up
      logic out_free;   // output register can take a beat
   } dp_status_type;

endpackage

>>> hw/rtl/bfde_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the queue entries.
module bfde_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read, held when idle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/bfde_dpath.sv
// Datapath of the replacement queue: registers, entry RAM, walk logic, output register.
// Depends on bfde_pkg, bfde_ram and assert_macros.svh.
`include "assert_macros.svh"

module bfde_dpath import bfde_pkg::*; #(
   parameter int DEPTH   = 64,
   parameter int ID_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_op,
   input  logic [ID_W-1:0]       req_actor_id,
   input  logic                  req_is_corpse,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  ctrl_cmd_type          cmd,
   output dp_status_type         status,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_destroy_valid,
   output logic [ID_W-1:0]       rsp_destroyed_id,
   output logic [COUNT_W-1:0]    rsp_queue_count,
   output logic                  rsp_last
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

   // Map a queue position to a RAM address, oldest entry at head
   function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                          input logic [CW-1:0] off);
      logic [AW:0] sum;
      sum = {1'b0, base} + (AW+1)'(off);
      if (sum >= (AW+1)'(DEPTH)) begin
         sum = sum - (AW+1)'(DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   logic                  filter_ff, filter_in;
   logic [CSR_DATA_W-1:0] qlimit_ff, qlimit_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [AW-1:0]         head_ff, head_in;
   logic [ID_BITS-1:0]    id_ff, id_in;
   logic [CW-1:0]         idx_ff, idx_in;
   logic [CW-1:0]         pidx_ff, pidx_in;
   logic                  pend_ff, pend_in;
   logic [OUT_CNT_W-1:0]  nout_ff, nout_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_dv_ff, rsp_dv_in;
   logic [ID_W-1:0]       rsp_id_ff, rsp_id_in;
   logic [COUNT_W-1:0]    rsp_cnt_ff, rsp_cnt_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [ID_BITS-1:0]    wr_data;
   logic                  rd_en;
   logic [AW-1:0]         rd_addr;
   logic [ID_BITS-1:0]    rd_data;

   logic [CW-1:0]         lim;
   logic                  out_load;
   logic                  ev_last;

   bfde_ram #(
      .WIDTH (ID_BITS),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Saturate the limit at the queue depth
   assign lim = (int'(qlimit_ff) > DEPTH) ? DEPTH_C : CW'(qlimit_ff);

   // Status toward the controller
   always_comb begin
      status.act       = (req_op == OP_REMOVE) || (filter_ff && req_is_corpse);
      status.enq_req   = (req_op == OP_ENQ);
      status.hit       = pend_ff && (rd_data == id_ff);
      status.walk_done = !pend_ff && (idx_ff >= count_ff);
      status.lim_zero  = (lim == '0);
      status.ev_need   = (count_ff >= lim);
      status.ev_more   = (count_ff > lim);
      status.n_zero    = (nout_ff == '0);
      status.n_full    = (nout_ff == OUT_CNT_W'(MAX_OUT));
      status.out_free  = !rsp_valid_ff || !rsp_stall;
   end

   // Final eviction, or the last one that still gets reported
   assign ev_last = !status.ev_more || (nout_ff == OUT_CNT_W'(MAX_OUT - 1));

   // Configuration writes
   always_comb begin
      filter_in = filter_ff;
      qlimit_in = qlimit_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_FILTER_ENABLE: filter_in = csr_wdata[0];
            CSR_QUEUE_LIMIT:   qlimit_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Queue walk, eviction, append and result load
   always_comb begin
      rd_en       = 1'b0;
      rd_addr     = phys(head_ff, idx_ff);
      wr_en       = 1'b0;
      wr_addr     = phys(head_ff, pidx_ff - CW'(1));
      wr_data     = rd_data;
      idx_in      = idx_ff;
      pidx_in     = pidx_ff;
      pend_in     = pend_ff;
      count_in    = count_ff;
      head_in     = head_ff;
      nout_in     = nout_ff;
      id_in       = id_ff;
      out_load    = 1'b0;
      rsp_dv_in   = rsp_dv_ff;
      rsp_id_in   = rsp_id_ff;
      rsp_cnt_in  = rsp_cnt_ff;
      rsp_last_in = rsp_last_ff;

      // Capture the item and restart the walk
      if (cmd.load) begin
         id_in   = ID_BITS'(req_actor_id);
         idx_in  = '0;
         pend_in = 1'b0;
         nout_in = '0;
      end

      // Walk one entry a cycle: compare or move down by one
      if (cmd.scan || cmd.shift) begin
         if (cmd.scan && status.hit) begin
            idx_in  = pidx_ff + CW'(1);
            pend_in = 1'b0;
         end else begin
            if (cmd.shift && pend_ff) begin
               wr_en = 1'b1;
            end
            if (idx_ff < count_ff) begin
               rd_en   = 1'b1;
               pend_in = 1'b1;
               pidx_in = idx_ff;
               idx_in  = idx_ff + CW'(1);
            end else begin
               pend_in = 1'b0;
            end
            if (cmd.shift && status.walk_done) begin
               count_in = count_ff - CW'(1);
            end
         end
      end

      // Fetch the oldest entry
      if (cmd.ev_read) begin
         rd_en   = 1'b1;
         rd_addr = head_ff;
      end

      // Drop the oldest entry, report it while budget remains
      if (cmd.evict) begin
         head_in  = phys(head_ff, CW'(1));
         count_in = count_ff - CW'(1);
         if (!status.n_full) begin
            out_load    = 1'b1;
            nout_in     = nout_ff + OUT_CNT_W'(1);
            rsp_dv_in   = 1'b1;
            rsp_id_in   = ID_W'(rd_data);
            rsp_cnt_in  = ev_last ? COUNT_W'(lim) : COUNT_W'(count_ff - CW'(1));
            rsp_last_in = ev_last;
         end
      end

      // Store the identifier at the tail
      if (cmd.append) begin
         wr_en    = 1'b1;
         wr_addr  = phys(head_ff, count_ff);
         wr_data  = id_ff;
         count_in = count_ff + CW'(1);
      end

      if (cmd.emit_none) begin
         out_load    = 1'b1;
         rsp_dv_in   = 1'b0;
         rsp_id_in   = '0;
         rsp_cnt_in  = COUNT_W'(count_ff);
         rsp_last_in = 1'b1;
      end

      if (cmd.emit_kill) begin
         out_load    = 1'b1;
         rsp_dv_in   = 1'b1;
         rsp_id_in   = ID_W'(id_ff);
         rsp_cnt_in  = COUNT_W'(count_ff);
         rsp_last_in = 1'b1;
      end

      // Output register: load a beat or drop the one taken
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         filter_ff    <= FILTER_RESET;
         qlimit_ff    <= QLIMIT_RESET;
         count_ff     <= '0;
         head_ff      <= '0;
         pend_ff      <= 1'b0;
         nout_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         filter_ff    <= filter_in;
         qlimit_ff    <= qlimit_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         pend_ff      <= pend_in;
         nout_ff      <= nout_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      id_ff       <= id_in;
      idx_ff      <= idx_in;
      pidx_ff     <= pidx_in;
      rsp_dv_ff   <= rsp_dv_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_cnt_ff  <= rsp_cnt_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_destroy_valid = rsp_dv_ff;
   assign rsp_destroyed_id  = rsp_id_ff;
   assign rsp_queue_count   = rsp_cnt_ff;
   assign rsp_last          = rsp_last_ff;

   `ASSERT_NEVER(a_evict_empty, clock, reset, cmd.evict && (count_ff == '0), "eviction from an empty queue")
   `ASSERT_NEVER(a_append_full, clock, reset, cmd.append && (count_ff >= DEPTH_C), "append to a full queue")
   `ASSERT_AT(a_emit_free, clock, reset, (cmd.emit_none || cmd.emit_kill) |-> (!rsp_valid_ff || !rsp_stall), "result overwrites a waiting beat")

endmodule

>>> hw/rtl/bfde_ctrl.sv
// Controller of the replacement queue: sequences scan, gap close, eviction and append.
// Depends on bfde_pkg.
module bfde_ctrl import bfde_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_SCAN    = 4'd1;
   localparam logic [3:0] ST_SHIFT   = 4'd2;
   localparam logic [3:0] ST_DECIDE  = 4'd3;
   localparam logic [3:0] ST_EV_RD   = 4'd4;
   localparam logic [3:0] ST_EV_EMIT = 4'd5;
   localparam logic [3:0] ST_APPEND  = 4'd6;
   localparam logic [3:0] ST_FINISH  = 4'd7;
   localparam logic [3:0] ST_DESTROY = 4'd8;

   logic [3:0] state_ff, state_in;
   logic       enq_ff, enq_in;

   // Take a new beat only between items
   assign req_stall = (state_ff != ST_IDLE);

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      enq_in   = enq_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               enq_in   = status.enq_req;
               state_in = status.act ? ST_SCAN : ST_FINISH;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.hit) begin
               state_in = ST_SHIFT;
            end else if (status.walk_done) begin
               state_in = ST_DECIDE;
            end
         end
         ST_SHIFT: begin
            cmd.shift = 1'b1;
            if (status.walk_done) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (!enq_ff) begin
               state_in = ST_FINISH;
            end else if (status.lim_zero) begin
               state_in = ST_DESTROY;
            end else if (status.ev_need) begin
               state_in = ST_EV_RD;
            end else begin
               state_in = ST_APPEND;
            end
         end
         ST_EV_RD: begin
            cmd.ev_read = 1'b1;
            state_in    = ST_EV_EMIT;
         end
         ST_EV_EMIT: begin
            if (status.out_free || status.n_full) begin
               cmd.evict = 1'b1;
               state_in  = status.ev_more ? ST_EV_RD : ST_APPEND;
            end
         end
         ST_APPEND: begin
            cmd.append = 1'b1;
            state_in   = status.n_zero ? ST_FINISH : ST_IDLE;
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.emit_none = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_DESTROY: begin
            if (status.out_free) begin
               cmd.emit_kill = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         enq_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         enq_ff   <= enq_in;
      end
   end

endmodule

>>> hw/rtl/bounded_fifo_with_dedup_evict.sv
// Top level of the bounded replacement queue: controller plus datapath.
// Depends on bfde_pkg, bfde_ctrl and bfde_dpath.
//
// Keeps up to DEPTH identifiers oldest first in a circular RAM. An enqueue with is_corpse set
// (while filter_enable is set) drops any earlier copy, evicts the oldest entries while the count
// is at or above queue_limit (each reported destroyed), then appends; a zero limit reports the
// identifier itself destroyed, and a limit above DEPTH acts as DEPTH. A removal drops the
// matching entry. Every item yields one or more result beats, the final one marked by last.
// Items are taken one at a time; the scan and the gap close walk the single-read entry RAM
// one entry a cycle. Once an item is taken, an ignored enqueue goes straight to its report.
// Any other item scans for an earlier copy, closes the gap behind a copy when one is found
// and then decides. A removal or a zero limit then reports; an enqueue reads and evicts each
// oldest entry in turn, then appends, and reports no destruction when nothing was evicted.
// Evictions move the head pointer, so they do not shift the queue. A report waits while the
// output register holds a stalled beat, and that beat waits there while the next item is
// taken. Configuration writes are always ready and apply from the next cycle; write them
// only while the block is idle.
module bounded_fifo_with_dedup_evict import bfde_pkg::*; #(
   parameter int DEPTH   = 64,
   parameter int ID_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_op,
   input  logic [ID_W-1:0]       req_actor_id,
   input  logic                  req_is_corpse,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_destroy_valid,
   output logic [ID_W-1:0]       rsp_destroyed_id,
   output logic [COUNT_W-1:0]    rsp_queue_count,
   output logic                  rsp_last,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   ctrl_cmd_type  cmd;
   dp_status_type status;
   logic          csr_write;

   // Registers take a write in any cycle
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   bfde_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   bfde_dpath #(
      .DEPTH   (DEPTH),
      .ID_BITS (ID_BITS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .req_op            (req_op),
      .req_actor_id      (req_actor_id),
      .req_is_corpse     (req_is_corpse),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .cmd               (cmd),
      .status            (status),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_destroy_valid (rsp_destroy_valid),
      .rsp_destroyed_id  (rsp_destroyed_id),
      .rsp_queue_count   (rsp_queue_count),
      .rsp_last          (rsp_last)
   );

endmodule

>>> dv/bfde_checker.sv
// Scoreboard for the bounded replacement queue: tracks the ordered entry list,
// predicts each result beat and compares it field by field. Depends on bfde_pkg.
`timescale 1ns / 1ps

module bfde_checker import bfde_pkg::*; #(
   parameter int DEPTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic                  req_op,
   input  logic [ID_W-1:0]       req_actor_id,
   input  logic                  req_is_corpse,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic                  rsp_destroy_valid,
   input  logic [ID_W-1:0]       rsp_destroyed_id,
   input  logic [COUNT_W-1:0]    rsp_queue_count,
   input  logic                  rsp_last,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    reports_open
);

   typedef struct packed {
      logic               destroy_valid;
      logic [ID_W-1:0]    destroyed_id;
      logic [COUNT_W-1:0] queue_count;
      logic               last;
   } destroy_report_type;

   // Shadow of the entry list, oldest first, and of the two registers
   logic [ID_W-1:0]       held_ids[$];
   destroy_report_type    expected_reports[$];
   logic                  filter_on;
   logic [CSR_DATA_W-1:0] limit_reg;

   // Drop the first copy of an identifier, closing the gap
   function automatic void drop_id(input logic [ID_W-1:0] id);
      for (int i = 0; i < held_ids.size(); i++) begin
         if (held_ids[i] == id) begin
            held_ids.delete(i);
            break;
         end
      end
   endfunction

   function automatic void post_report(input logic valid, input logic [ID_W-1:0] id);
      expected_reports.push_back('{valid, id, COUNT_W'(held_ids.size()), 1'b1});
   endfunction

   // Work out the beats one accepted item causes and update the shadow list
   function automatic void predict_item(input logic op, input logic [ID_W-1:0] id,
                                        input logic corpse);
      int                 lim;
      int                 n;
      logic [ID_W-1:0]    oldest;
      destroy_report_type evicted;
      n = 0;
      evicted = '0;
      if (op == OP_REMOVE) begin
         drop_id(id);
         post_report(1'b0, '0);
         return;
      end
      if (!filter_on || !corpse) begin
         post_report(1'b0, '0);
         return;
      end
      drop_id(id);
      lim = (int'(limit_reg) > DEPTH) ? DEPTH : int'(limit_reg);
      if (lim == 0) begin
         post_report(1'b1, id);
         return;
      end
      // Evict oldest entries; hold back the latest beat so it can be marked last
      while (held_ids.size() >= lim && held_ids.size() > 0) begin
         oldest = held_ids.pop_front();
         if (n < MAX_OUT) begin
            if (n > 0) expected_reports.push_back(evicted);
            evicted = '{1'b1, oldest, COUNT_W'(held_ids.size()), 1'b0};
            n++;
         end
      end
      if (held_ids.size() < DEPTH) held_ids.push_back(id);
      if (n == 0) begin
         post_report(1'b0, '0);
      end else begin
         evicted.queue_count = COUNT_W'(held_ids.size());
         evicted.last = 1'b1;
         expected_reports.push_back(evicted);
      end
   endfunction

   function automatic void check_field(input string name, input logic [ID_W-1:0] want,
                                       input logic [ID_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         held_ids.delete();
         expected_reports.delete();
         filter_on = FILTER_RESET;
         limit_reg = QLIMIT_RESET;
      end else begin
         // Register writes
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_FILTER_ENABLE) filter_on = csr_wdata[0];
            else if (csr_index == CSR_QUEUE_LIMIT) limit_reg = csr_wdata;
         end
         // Compare a result beat against the oldest expectation
         if (rsp_valid && !rsp_stall) begin
            if (expected_reports.size() == 0) begin
               $error("unexpected result beat: destroyed_id %0d, queue_count %0d",
                      rsp_destroyed_id, rsp_queue_count);
               fail_count++;
            end else begin
               check_field("destroy_valid", ID_W'(expected_reports[0].destroy_valid),
                           ID_W'(rsp_destroy_valid));
               check_field("destroyed_id", expected_reports[0].destroyed_id, rsp_destroyed_id);
               check_field("queue_count", ID_W'(expected_reports[0].queue_count),
                           ID_W'(rsp_queue_count));
               check_field("last", ID_W'(expected_reports[0].last), ID_W'(rsp_last));
               expected_reports.delete(0);
            end
         end
         // Predict the beats of a newly accepted item
         if (req_valid && !req_stall) predict_item(req_op, req_actor_id, req_is_corpse);
      end
      reports_open <= expected_reports.size();
   end

endmodule

>>> dv/tb_bounded_fifo_with_dedup_evict.sv
// Top of the replacement queue testbench: clock, reset, stimulus and verdict.
// Depends on bfde_pkg, bfde_checker and the bounded_fifo_with_dedup_evict RTL.
`timescale 1ns / 1ps

module tb_bounded_fifo_with_dedup_evict;
   import bfde_pkg::*;

   localparam int POOL_N = 12;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_op = OP_ENQ;
   logic [ID_W-1:0]       req_actor_id = '0;
   logic                  req_is_corpse = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_destroy_valid;
   logic [ID_W-1:0]       rsp_destroyed_id;
   logic [COUNT_W-1:0]    rsp_queue_count;
   logic                  rsp_last;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_FILTER_ENABLE;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int                    check_errors;
   int                    reports_open;
   logic                  steady = 1'b0;
   logic                  hold_rsp = 1'b0;
   logic                  pressure_go = 1'b0;
   logic [ID_W-1:0]       id_pool[POOL_N];

   bounded_fifo_with_dedup_evict uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_op(req_op),
      .req_actor_id(req_actor_id), .req_is_corpse(req_is_corpse),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_destroy_valid(rsp_destroy_valid), .rsp_destroyed_id(rsp_destroyed_id),
      .rsp_queue_count(rsp_queue_count), .rsp_last(rsp_last),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   bfde_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_op(req_op),
      .req_actor_id(req_actor_id), .req_is_corpse(req_is_corpse),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_destroy_valid(rsp_destroy_valid), .rsp_destroyed_id(rsp_destroyed_id),
      .rsp_queue_count(rsp_queue_count), .rsp_last(rsp_last),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(check_errors), .reports_open(reports_open)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Result side: random stalls, none while steady, solid during a hold-off
   always @(posedge clock) begin
      rsp_stall <= hold_rsp || (!steady && $urandom_range(0, 99) < 38);
   end

   // Long receiver hold-off so the block backs up into its input
   initial begin
      wait (pressure_go);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (400) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   initial begin
      #5_000_000;
      $display("tb_bounded_fifo_with_dedup_evict: done, errors");
      $finish;
   end

   // Offer one item after an optional gap and hold it until accepted
   task automatic send_item(input logic op, input logic [ID_W-1:0] id, input logic corpse);
      while (!steady && $urandom_range(0, 99) < 38) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_op        <= op;
      req_actor_id  <= id;
      req_is_corpse <= corpse;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Drop valid and wait until every expected beat has come back
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (reports_open != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic set_config(input logic fe, input logic [CSR_DATA_W-1:0] lim);
      wait_idle();
      write_csr(CSR_FILTER_ENABLE, {{(CSR_DATA_W-1){1'b0}}, fe});
      write_csr(CSR_QUEUE_LIMIT, lim);
      csr_valid <= 1'b0;
   endtask

   // Mixed enqueues and removals, mostly on a small set of ids to force hits
   task automatic send_mixed(input int n);
      int              pick;
      logic [ID_W-1:0] id;
      for (int k = 0; k < n; k++) begin
         pick = $urandom_range(0, 99);
         if ($urandom_range(0, 3) != 0) id = id_pool[$urandom_range(0, POOL_N - 1)];
         else id = ID_W'($urandom_range(0, 65535));
         if (pick < 25) send_item(OP_REMOVE, id, 1'($urandom_range(0, 1)));
         else send_item(OP_ENQ, id, pick < 90);
      end
   endtask

   // Enqueue a run of distinct ids from a random base
   task automatic send_fill(input int n);
      logic [ID_W-1:0] base;
      base = ID_W'($urandom_range(0, 65535));
      for (int k = 0; k < n; k++) send_item(OP_ENQ, base + ID_W'(k), 1'b1);
   endtask

   initial begin
      foreach (id_pool[i]) id_pool[i] = ID_W'($urandom_range(0, 65535));
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: id extremes, duplicate, ignored enqueue, removal hit and miss
      send_item(OP_ENQ, 16'h0000, 1'b1);
      send_item(OP_ENQ, 16'hFFFF, 1'b1);
      send_item(OP_ENQ, 16'h1234, 1'b1);
      send_item(OP_ENQ, 16'h0000, 1'b1);
      send_item(OP_ENQ, 16'h5555, 1'b0);
      send_item(OP_REMOVE, 16'hFFFF, 1'b0);
      send_item(OP_REMOVE, 16'h4242, 1'b0);
      send_item(OP_REMOVE, 16'h0000, 1'b1);
      // Filter off: enqueue ignored, removal still honored
      set_config(1'b0, 7'd64);
      send_item(OP_ENQ, 16'h7777, 1'b1);
      send_item(OP_REMOVE, 16'h1234, 1'b1);
      set_config(1'b1, 7'd64);
      send_item(OP_ENQ, 16'h00AA, 1'b1);
      send_item(OP_ENQ, 16'h00BB, 1'b1);
      // Zero limit: old copy removed, id reported destroyed itself
      set_config(1'b1, 7'd0);
      send_item(OP_ENQ, 16'h00AA, 1'b1);
      send_item(OP_ENQ, 16'hA5A5, 1'b1);
      // Small limit: evictions of the oldest
      set_config(1'b1, 7'd2);
      send_item(OP_ENQ, 16'h0001, 1'b1);
      send_item(OP_ENQ, 16'h0002, 1'b1);
      send_item(OP_ENQ, 16'h0003, 1'b1);
      send_item(OP_ENQ, 16'h0002, 1'b1);

      // Fill past full with no idling on either side
      set_config(1'b1, 7'd64);
      steady <= 1'b1;
      send_fill(66);
      wait_idle();
      steady <= 1'b0;

      // Shrink the limit to one: every held entry evicted in one run
      set_config(1'b1, 7'd1);
      send_fill(1);
      send_mixed(10);

      set_config(1'b1, 7'd5);
      pressure_go <= 1'b1;
      send_mixed(20);

      set_config(1'b1, 7'd0);
      send_mixed(5);

      // Out-of-range limit acts as full depth, then shrink it
      set_config(1'b1, 7'd127);
      send_fill(20);
      send_mixed(10);
      set_config(1'b1, 7'd3);
      send_mixed(5);

      set_config(1'b0, 7'd16);
      send_mixed(5);

      set_config(1'b1, 7'd12);
      send_mixed(10);

      wait_idle();
      repeat (200) @(posedge clock);
      if (check_errors == 0 && reports_open == 0) begin
         $display("tb_bounded_fifo_with_dedup_evict: done, clean");
      end else begin
         $display("tb_bounded_fifo_with_dedup_evict: done, errors");
      end
      $finish;
   end

endmodule
